/* design/b64d_pkg.sv */
// Shared types, constants and the character-to-symbol map for the base64 stream decoder.
// Used by every module of the decoder; no dependencies of its own.
package b64d_pkg;

    localparam int QDepth = 4;
    localparam int QPtrW  = $clog2(QDepth);
    localparam int QCntW  = $clog2(QDepth + 1);

    localparam logic [7:0] CharPad   = 8'h3D;  // '='
    localparam logic [7:0] CharUpA   = 8'h41;
    localparam logic [7:0] CharUpZ   = 8'h5A;
    localparam logic [7:0] CharLoA   = 8'h61;
    localparam logic [7:0] CharLoZ   = 8'h7A;
    localparam logic [7:0] CharDig0  = 8'h30;
    localparam logic [7:0] CharDig9  = 8'h39;
    localparam logic [7:0] CharPlus  = 8'h2B;
    localparam logic [7:0] CharSlash = 8'h2F;

    localparam logic [7:0] SymLoBase  = 8'd26;
    localparam logic [7:0] SymDigBase = 8'd52;
    localparam logic [5:0] SymPlus    = 6'd62;
    localparam logic [5:0] SymSlash   = 6'd63;

    // One queued group: the results that one character causes
    typedef struct packed {
        logic [2:0][7:0] bytes;      // bytes[0] leaves first
        logic [1:0]      nres;       // number of results, 1..3
        logic            has_bytes;  // 0: a single end marker without data
        logic            eom;        // final result of the group ends the message
        logic            empty;      // message produced no byte
    } b64d_entry_t;

    // bit 6: character is a symbol, bits 5:0: its value
    function automatic logic [6:0] sym_decode(input logic [7:0] ch);
        logic [7:0] t;
        logic [6:0] r;
        t = 8'd0;
        r = 7'd0;
        if (ch >= CharUpA && ch <= CharUpZ) begin
            t = ch - CharUpA;
            r = {1'b1, t[5:0]};
        end else if (ch >= CharLoA && ch <= CharLoZ) begin
            t = ch - CharLoA + SymLoBase;
            r = {1'b1, t[5:0]};
        end else if (ch >= CharDig0 && ch <= CharDig9) begin
            t = ch - CharDig0 + SymDigBase;
            r = {1'b1, t[5:0]};
        end else if (ch == CharPlus) begin
            r = {1'b1, SymPlus};
        end else if (ch == CharSlash) begin
            r = {1'b1, SymSlash};
        end
        return r;
    endfunction

endpackage

/* design/base64_stream_decoder.sv */
// Top level of the streaming base64 decoder: front end, group queue, output stage.
// Depends on b64d_pkg, b64d_front, b64d_queue, b64d_back.
//
//  channel | dir | tdata            | tlast          | tuser
//  s_      | in  | char_in[7:0]     | last_char      | -
//  m_      | out | out_byte[7:0]    | end_of_message | [0] byte_valid, [1] message_empty
//
// One character is taken per cycle while the 4-entry group queue has room.
// Results leave at one per cycle from the output register while m_tready is high;
// a character completing a quad yields three, the queue absorbs that burst, and as
// no character averages more than one result, one character per cycle is sustained.
// m_tvalid rises once results pass the queue slot and then the output register.
// aresetn clears the decoder state, queue pointers and output valid; no clearing pass.
module base64_stream_decoder import b64d_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_in
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,
    output logic [1:0] m_tuser    // [0] byte_valid, [1] message_empty
);

    b64d_entry_t push_entry, head;
    logic        push, full, pop, head_valid;

    b64d_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (full),
        .q_push   (push),
        .q_entry  (push_entry)
    );

    b64d_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    b64d_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

/* design/b64d_front.sv */
// Front end: takes characters, keeps the quad accumulator and builds result groups.
// Depends on b64d_pkg.
module b64d_front import b64d_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // char_in
    input  logic        s_tlast,   // last_char
    input  logic        q_full,
    output logic        q_push,
    output b64d_entry_t q_entry
);

    logic [17:0] acc_reg, acc_next, acc_mid;
    logic [1:0]  cnt_reg, cnt_next, cnt_mid;
    logic        pad_reg, pad_next;
    logic        any_reg, any_next;

    logic [6:0]  sym;
    logic        is_pad, is_sym, quad_done, accept;
    logic [23:0] acc24;

    assign s_tready  = !q_full;
    assign accept    = s_tvalid && s_tready;
    assign sym       = sym_decode(s_tdata);
    assign is_pad    = s_tdata == CharPad;
    assign is_sym    = !pad_reg && !is_pad && sym[6];
    assign acc24     = {acc_reg, sym[5:0]};
    assign quad_done = is_sym && (cnt_reg == 2'd3);
    assign q_push    = accept && (quad_done || s_tlast);

    always_comb begin
        if (quad_done) begin
            acc_mid = 18'd0;
            cnt_mid = 2'd0;
        end else if (is_sym) begin
            acc_mid = acc24[17:0];
            cnt_mid = cnt_reg + 2'd1;
        end else begin
            acc_mid = acc_reg;
            cnt_mid = cnt_reg;
        end
    end

    always_comb begin
        q_entry.bytes     = '0;
        q_entry.nres      = 2'd1;
        q_entry.has_bytes = 1'b1;
        priority if (quad_done) begin
            q_entry.bytes[0] = acc24[23:16];
            q_entry.bytes[1] = acc24[15:8];
            q_entry.bytes[2] = acc24[7:0];
            q_entry.nres     = 2'd3;
        end else if (cnt_mid == 2'd2) begin
            q_entry.bytes[0] = acc_mid[11:4];
        end else if (cnt_mid == 2'd3) begin
            q_entry.bytes[0] = acc_mid[17:10];
            q_entry.bytes[1] = acc_mid[9:2];
            q_entry.nres     = 2'd2;
        end else begin
            q_entry.has_bytes = 1'b0;   // tail with nothing to flush
        end
        q_entry.eom   = s_tlast;
        q_entry.empty = !(any_reg || q_entry.has_bytes);
    end

    always_comb begin
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        pad_next = pad_reg;
        any_next = any_reg;
        if (accept) begin
            if (s_tlast) begin
                acc_next = 18'd0;
                cnt_next = 2'd0;
                pad_next = 1'b0;
                any_next = 1'b0;
            end else begin
                acc_next = acc_mid;
                cnt_next = cnt_mid;
                pad_next = pad_reg || is_pad;
                any_next = any_reg || quad_done;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= 18'd0;
            cnt_reg <= 2'd0;
            pad_reg <= 1'b0;
            any_reg <= 1'b0;
        end else begin
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
            pad_reg <= pad_next;
            any_reg <= any_next;
        end
    end

endmodule

/* design/b64d_queue.sv */
// Small register queue of result groups between front end and output stage.
// Depends on b64d_pkg.
module b64d_queue import b64d_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  b64d_entry_t push_entry,
    output logic        full,
    input  logic        pop,
    output logic        head_valid,
    output b64d_entry_t head
);

    b64d_entry_t slot_reg [QDepth];
    logic [QPtrW-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [QCntW-1:0] cnt_reg, cnt_next;

    assign full       = cnt_reg == QCntW'(QDepth);
    assign head_valid = cnt_reg != '0;
    assign head       = slot_reg[rd_reg];

    always_comb begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + QCntW'(push) - QCntW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push || pop)
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("queue popped while empty");
    a_ptr_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_reg == rd_reg) |-> (cnt_reg == '0 || full))
        else $error("queue pointers disagree with fill count");
`endif

endmodule

/* design/b64d_back.sv */
// Output stage: splits each queued group into single results behind an output register.
// Depends on b64d_pkg.
module b64d_back import b64d_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        head_valid,
    input  b64d_entry_t head,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,
    output logic        m_tlast,
    output logic [1:0]  m_tuser
);

    logic [1:0] idx_reg, idx_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic [7:0] byte_reg, byte_next;
    logic       last_reg, last_next;
    logic [1:0] user_reg, user_next;
    logic       load, final_res;
    logic [7:0] sel_byte;

    assign load      = head_valid && (!m_tvalid_reg || m_tready);
    assign final_res = idx_reg == head.nres - 2'd1;
    assign pop       = load && final_res;

    always_comb begin
        unique case (idx_reg)
            2'd0:    sel_byte = head.bytes[0];
            2'd1:    sel_byte = head.bytes[1];
            default: sel_byte = head.bytes[2];
        endcase
    end

    always_comb begin
        idx_next      = idx_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        byte_next     = byte_reg;
        last_next     = last_reg;
        user_next     = user_reg;
        if (load) begin
            idx_next      = final_res ? 2'd0 : idx_reg + 2'd1;
            m_tvalid_next = 1'b1;
            byte_next     = head.has_bytes ? sel_byte : 8'd0;
            last_next     = head.eom && final_res;
            user_next     = {head.eom && final_res && head.empty, head.has_bytes};
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
        last_reg <= last_next;
        user_reg <= user_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg      <= 2'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            idx_reg      <= idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = byte_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = user_reg;

`ifndef SYNTHESIS
    a_idx_in_group: assert property (@(posedge aclk) disable iff (!aresetn)
        head_valid |-> idx_reg < head.nres)
        else $error("result index past end of group");
    a_empty_marks_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tlast && !m_tuser[0])
        else $error("message_empty outside a bare end marker");
    a_nodata_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == 8'd0 && m_tlast)
        else $error("result without byte is not a zero end marker");
`endif

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for base64_stream_decoder: directed messages, then random messages.
// A local decoder model predicts every result; needs b64d_pkg and the decoder RTL.
module testbench;
    import b64d_pkg::*;

    localparam int CycleLimit = 200000;
    localparam int RandomItems = 176;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       eom;
        logic       empty;
    } byte_result_t;

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic [1:0] m_tuser;

    byte_result_t expected_bytes[$];
    int           mismatches;
    int           chars_sent;
    int           cycles;
    bit           steady_flow;

    // decoder model state
    logic [17:0] quad_bits;
    logic [1:0]  sym_cnt;
    logic        pad_seen;
    logic        any_written;

    base64_stream_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic bit sym_lookup(input logic [7:0] ch, output logic [5:0] val);
        logic [7:0] t;
        t = 8'd0;
        val = 6'd0;
        if (ch >= CharUpA && ch <= CharUpZ) begin
            t = ch - CharUpA;
        end else if (ch >= CharLoA && ch <= CharLoZ) begin
            t = ch - CharLoA + 8'd26;
        end else if (ch >= CharDig0 && ch <= CharDig9) begin
            t = ch - CharDig0 + 8'd52;
        end else if (ch == CharPlus) begin
            t = 8'd62;
        end else if (ch == CharSlash) begin
            t = 8'd63;
        end else begin
            return 1'b0;
        end
        val = t[5:0];
        return 1'b1;
    endfunction

    function automatic logic [7:0] b64_char_of(input int idx);
        if (idx < 26) return CharUpA + idx[7:0];
        if (idx < 52) return CharLoA + idx[7:0] - 8'd26;
        if (idx < 62) return CharDig0 + idx[7:0] - 8'd52;
        if (idx == 62) return CharPlus;
        return CharSlash;
    endfunction

    task automatic decode_char(input logic [7:0] ch, input logic last);
        logic [23:0]  acc;
        logic [5:0]   v;
        logic [7:0]   outs[3];
        int           n;
        byte_result_t r;
        n = 0;
        if (!pad_seen) begin
            if (ch == CharPad) begin
                pad_seen = 1'b1;
            end else if (sym_lookup(ch, v)) begin
                acc = {quad_bits, v};
                if (sym_cnt == 2'd3) begin
                    outs[0] = acc[23:16];
                    outs[1] = acc[15:8];
                    outs[2] = acc[7:0];
                    n = 3;
                    quad_bits = '0;
                    sym_cnt = '0;
                end else begin
                    quad_bits = acc[17:0];
                    sym_cnt = sym_cnt + 2'd1;
                end
            end
        end
        // tail flush of a partial quad
        if (last) begin
            if (sym_cnt == 2'd2) begin
                outs[n] = quad_bits[11:4];
                n++;
            end else if (sym_cnt == 2'd3) begin
                outs[n] = quad_bits[17:10];
                outs[n + 1] = quad_bits[9:2];
                n += 2;
            end
        end
        if (n > 0) any_written = 1'b1;
        for (int k = 0; k < n; k++) begin
            r.data  = outs[k];
            r.valid = 1'b1;
            r.eom   = last && (k == n - 1);
            r.empty = 1'b0;
            expected_bytes.push_back(r);
        end
        if (last) begin
            if (n == 0) begin
                r.data  = 8'd0;
                r.valid = 1'b0;
                r.eom   = 1'b1;
                r.empty = !any_written;
                expected_bytes.push_back(r);
            end
            quad_bits   = '0;
            sym_cnt     = '0;
            pad_seen    = 1'b0;
            any_written = 1'b0;
        end
    endtask

    // accepted characters feed the model; accepted results are checked
    always @(posedge aclk) begin
        byte_result_t want;
        cycles++;
        if (cycles > CycleLimit) begin
            $display("[FAIL] regression broken");
            $finish;
        end
        if (aresetn && s_tvalid && s_tready) decode_char(s_tdata, s_tlast);
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_bytes.size() == 0) begin
                $display("%0t: result: expected none, got data %h last %b user %b",
                         $time, m_tdata, m_tlast, m_tuser);
                mismatches++;
            end else begin
                want = expected_bytes.pop_front();
                if (m_tdata !== want.data) begin
                    $display("%0t: out_byte: expected %h, got %h", $time, want.data, m_tdata);
                    mismatches++;
                end
                if (m_tuser[0] !== want.valid) begin
                    $display("%0t: byte_valid: expected %b, got %b",
                             $time, want.valid, m_tuser[0]);
                    mismatches++;
                end
                if (m_tlast !== want.eom) begin
                    $display("%0t: end_of_message: expected %b, got %b",
                             $time, want.eom, m_tlast);
                    mismatches++;
                end
                if (m_tuser[1] !== want.empty) begin
                    $display("%0t: message_empty: expected %b, got %b",
                             $time, want.empty, m_tuser[1]);
                    mismatches++;
                end
            end
        end
    end

    always @(negedge aclk) begin
        m_tready <= steady_flow || ($urandom_range(99) >= 18);
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_char(input logic [7:0] ch, input logic last);
        while (!steady_flow && $urandom_range(99) < 18) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        chars_sent++;
    endtask

    task automatic send_msg(input string text);
        for (int i = 0; i < text.len(); i++) send_char(text[i], i == text.len() - 1);
    endtask

    task automatic test_full_quad();
        // quad completed by the last character: three bytes, end on the third
        send_msg("TWFu");
    endtask

    task automatic test_tail_flush();
        send_msg("/+");
        send_msg("09z");
        send_msg("a");  // single leftover symbol is dropped, message empty
    endtask

    task automatic test_padding();
        send_char("Z", 1'b0);
        send_char("A", 1'b0);
        send_char(CharPad, 1'b0);
        send_char("Q", 1'b0);    // ignored after padding
        send_char(8'hFF, 1'b1);  // skipped, but tail still flushes
        send_char(CharPad, 1'b1);
    endtask

    task automatic test_skipped_chars();
        send_char(8'h00, 1'b0);
        send_char("A", 1'b0);
        send_char("A", 1'b0);
        send_char("A", 1'b0);
        send_char(8'h80, 1'b0);
        send_char("A", 1'b0);
        send_char(8'h0A, 1'b1);  // end marker only, bytes already written
        send_char(8'hFF, 1'b1);  // message of nothing but noise
    endtask

    task automatic test_random_messages();
        int         start;
        int         kind;
        int         len;
        int         pad_at;
        logic [7:0] ch;
        start = chars_sent;
        while (chars_sent - start < RandomItems) begin
            steady_flow = (chars_sent - start >= 70) && (chars_sent - start < 130);
            kind   = $urandom_range(99);
            len    = $urandom_range(1, 12);
            pad_at = (kind >= 15 && kind < 35) ? $urandom_range(0, len - 1) : len;
            for (int i = 0; i < len; i++) begin
                ch = b64_char_of($urandom_range(63));
                if (kind < 15 || $urandom_range(99) < 8) ch = 8'($urandom_range(255));
                if (i == pad_at) ch = CharPad;
                send_char(ch, i == len - 1);
            end
        end
        steady_flow = 1'b0;
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = 8'd0;
        s_tlast     = 1'b0;
        m_tready    = 1'b0;
        mismatches  = 0;
        chars_sent  = 0;
        cycles      = 0;
        steady_flow = 1'b0;
        quad_bits   = '0;
        sym_cnt     = '0;
        pad_seen    = 1'b0;
        any_written = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_full_quad();
        test_tail_flush();
        test_padding();
        test_skipped_chars();
        test_random_messages();
        s_tvalid <= 1'b0;

        wait (expected_bytes.size() == 0);
        repeat (20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

/* filelist.f */
design/b64d_pkg.sv
design/b64d_front.sv
design/b64d_queue.sv
design/b64d_back.sv
design/base64_stream_decoder.sv
sim/testbench.sv
